// ===== rtl/core/wave_grid_stencil_update_unit_assert.svh =====
// Assertion macros for the wave grid stencil block.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef WAVE_GRID_STENCIL_UPDATE_UNIT_ASSERT_SVH
`define WAVE_GRID_STENCIL_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define WGSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WGSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wgsu_pkg.sv =====
`timescale 1ns / 1ps

package wgsu_pkg;

  // opcodes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_PERTURB = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_GRID_ROWS   = 3'd0;
  localparam logic [2:0] CFG_GRID_COLS   = 3'd1;
  localparam logic [2:0] CFG_COEFF_PREV  = 3'd2;
  localparam logic [2:0] CFG_COEFF_CUR   = 3'd3;
  localparam logic [2:0] CFG_COEFF_NBR   = 3'd4;
  localparam logic [2:0] CFG_STEP_PERIOD = 3'd5;

  localparam logic [16:0]        ACC_MAX    = 17'h1FFFF;
  localparam logic signed [35:0] ROUND_BIAS = 36'sd8192;
  localparam int                 FRAC_SHIFT = 14;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_DN,
    ST_LF,
    ST_RT,
    ST_CT,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_WB,
    ST_PRD,
    ST_PWR,
    ST_RD,
    ST_RDC,
    ST_RES
  } state_e;

endpackage

// ===== rtl/core/wave_grid_stencil_update_unit.sv =====
`timescale 1ns / 1ps

// Ripple simulator over two Q8.8 height grids (previous and current), each a
// MAX_ROWS*MAX_COLS memory with one read and one write port. After reset the
// block sweeps both grids to zero, one address per cycle, and holds in_stall_o
// high meanwhile; config writes are taken at any time. One item is worked at a
// time: a perturb is a read-modify-write of five cells, one after another,
// through the current grid's read and write ports. A stepping tick visits every
// active cell in turn: a boundary cell only has zero written to the previous
// grid, an interior cell is paced by the five reads of the current grid and the
// one shared 16x18 multiplier that forms the three Q2.14 products in sequence.
// A finished result sits in an output register so the next item can start.
module wave_grid_stencil_update_unit
  import wgsu_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [5:0]         cell_row_i,
  input  logic [5:0]         cell_col_i,
  input  logic signed [15:0] magnitude_i,
  input  logic [15:0]        delta_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] height_o,
  output logic               stepped_o,
  output logic               rejected_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_COLS);
  localparam logic [6:0] ROWS_CAP = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);
  localparam logic [6:0] COLS_CAP = (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);

  function automatic logic signed [15:0] sat_h(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -36'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  // configuration
  logic [6:0]         grid_rows_q, grid_cols_q;
  logic signed [15:0] coeff_prev_q, coeff_cur_q, coeff_nbr_q;
  logic [15:0]        step_period_q;

  logic [AW-1:0] clr_q;
  logic [16:0]   acc_q;
  logic          cur_is_b_q;

  // cell sweep
  logic [6:0]    r_q, c_q;
  logic [AW-1:0] k_q, base_q;
  logic [2:0]    pidx_q;

  // datapath
  logic [AW-1:0]      addr_q;
  logic signed [15:0] mag_q;
  logic signed [17:0] nsum_q;
  logic signed [15:0] prv_val_q, ctr_val_q;
  logic signed [33:0] prod_q;
  logic signed [35:0] sum_q;
  logic signed [15:0] res_height_q;
  logic               res_stepped_q, res_rejected_q;

  logic               out_valid_q;
  logic signed [15:0] out_height_q;
  logic               out_stepped_q, out_rejected_q;

  // memories
  logic [15:0]   mem_a [DEPTH];
  logic [15:0]   mem_b [DEPTH];
  logic [15:0]   a_rd_q, b_rd_q;
  logic [AW-1:0] a_ra, b_ra;
  logic          a_we, b_we;
  logic [AW-1:0] cur_ra, prv_ra, wr_addr;
  logic          cur_we, prv_we, clr_we;
  logic [15:0]   wr_data;
  logic signed [15:0] cur_rd_s, prv_rd_s;

  // decode
  logic [6:0]  rows_act, cols_act;
  logic [7:0]  row8, col8, rows8, cols8;
  logic        perturb_ok, read_ok, no_cells;
  logic [17:0] acc_sum;
  logic [16:0] acc_sat;
  logic        step_due;
  logic        in_fire, out_free;
  logic        is_edge, last_col, last_row, last_cell;
  logic [AW-1:0] cell_addr, p_addr;

  logic signed [15:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [33:0] mul_out;
  logic signed [35:0] rnd, shifted, psum;
  logic signed [15:0] wb_val, addend;

  assign rows_act = (grid_rows_q > ROWS_CAP) ? ROWS_CAP : grid_rows_q;
  assign cols_act = (grid_cols_q > COLS_CAP) ? COLS_CAP : grid_cols_q;
  assign row8  = {2'b00, cell_row_i};
  assign col8  = {2'b00, cell_col_i};
  assign rows8 = {1'b0, rows_act};
  assign cols8 = {1'b0, cols_act};

  assign perturb_ok = (row8 >= 8'd2) && (row8 + 8'd2 < rows8) &&
                      (col8 >= 8'd2) && (col8 + 8'd2 < cols8);
  assign read_ok    = (row8 < rows8) && (col8 < cols8);
  assign no_cells   = (rows_act == 7'd0) || (cols_act == 7'd0);
  assign cell_addr  = AW'(int'(cell_row_i) * MAX_COLS + int'(cell_col_i));

  assign acc_sum  = {1'b0, acc_q} + {2'b00, delta_time_i};
  assign acc_sat  = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[16:0];
  assign step_due = ({1'b0, acc_sat} >= {2'b00, step_period_q});

  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign last_col  = ({1'b0, c_q} + 8'd1 >= cols8);
  assign last_row  = ({1'b0, r_q} + 8'd1 >= rows8);
  assign last_cell = last_col && last_row;
  assign is_edge   = (r_q == 7'd0) || (c_q == 7'd0) || last_col || last_row;

  assign cur_rd_s = cur_is_b_q ? $signed(b_rd_q) : $signed(a_rd_q);
  assign prv_rd_s = cur_is_b_q ? $signed(a_rd_q) : $signed(b_rd_q);

  assign mul_out = mul_a * mul_b;
  assign rnd     = sum_q + ROUND_BIAS;
  assign shifted = rnd >>> FRAC_SHIFT;
  assign wb_val  = sat_h(shifted);

  // centre gets the full magnitude, the four neighbours floor(mag/2)
  assign addend = (pidx_q == 3'd0) ? mag_q : (mag_q >>> 1);
  assign psum   = 36'(cur_rd_s) + 36'(addend);

  always_comb begin
    case (pidx_q)
      3'd0:    p_addr = addr_q;
      3'd1:    p_addr = addr_q + AW'(1);
      3'd2:    p_addr = addr_q - AW'(1);
      3'd3:    p_addr = addr_q + ROW_STRIDE;
      default: p_addr = addr_q - ROW_STRIDE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_TICK: begin
              if (step_due && !no_cells) state_d = ST_CELL;
              else                       state_d = ST_RES;
            end
            OP_PERTURB: state_d = perturb_ok ? ST_PRD : ST_RES;
            OP_READ:    state_d = read_ok ? ST_RD : ST_RES;
            default:    state_d = ST_RES;
          endcase
        end
      end
      ST_CELL: begin
        if (!is_edge)      state_d = ST_DN;
        else if (last_cell) state_d = ST_RES;
      end
      ST_DN: state_d = ST_LF;
      ST_LF: state_d = ST_RT;
      ST_RT: state_d = ST_CT;
      ST_CT: state_d = ST_M1;
      ST_M1: state_d = ST_M2;
      ST_M2: state_d = ST_M3;
      ST_M3: state_d = ST_M4;
      ST_M4: state_d = ST_WB;
      ST_WB: state_d = last_cell ? ST_RES : ST_CELL;
      ST_PRD: state_d = ST_PWR;
      ST_PWR: state_d = (pidx_q == 3'd4) ? ST_RES : ST_PRD;
      ST_RD:  state_d = ST_RDC;
      ST_RDC: state_d = ST_RES;
      ST_RES: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory controls and multiplier operands
  always_comb begin
    cur_ra  = k_q;
    prv_ra  = k_q;
    cur_we  = 1'b0;
    prv_we  = 1'b0;
    clr_we  = 1'b0;
    wr_addr = k_q;
    wr_data = '0;
    mul_a   = coeff_prev_q;
    mul_b   = 18'(prv_val_q);
    case (state_q)
      ST_CLEAR: begin
        clr_we  = 1'b1;
        wr_addr = clr_q;
      end
      ST_CELL: begin
        cur_ra = k_q - ROW_STRIDE;
        prv_we = is_edge;
      end
      ST_DN: cur_ra = k_q + ROW_STRIDE;
      ST_LF: cur_ra = k_q - AW'(1);
      ST_RT: cur_ra = k_q + AW'(1);
      ST_CT: cur_ra = k_q;
      ST_M2: begin
        mul_a = coeff_cur_q;
        mul_b = 18'(ctr_val_q);
      end
      ST_M3: begin
        mul_a = coeff_nbr_q;
        mul_b = nsum_q;
      end
      ST_WB: begin
        prv_we  = 1'b1;
        wr_data = wb_val;
      end
      ST_PRD: cur_ra = p_addr;
      ST_PWR: begin
        cur_we  = 1'b1;
        wr_addr = p_addr;
        wr_data = sat_h(psum);
      end
      ST_RD, ST_RDC: cur_ra = addr_q;
      default: ;
    endcase
  end

  assign a_ra = cur_is_b_q ? prv_ra : cur_ra;
  assign b_ra = cur_is_b_q ? cur_ra : prv_ra;
  assign a_we = clr_we || (cur_is_b_q ? prv_we : cur_we);
  assign b_we = clr_we || (cur_is_b_q ? cur_we : prv_we);

  always_ff @(posedge clk_i) begin
    if (a_we) mem_a[wr_addr] <= wr_data;
    a_rd_q <= mem_a[a_ra];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) mem_b[wr_addr] <= wr_data;
    b_rd_q <= mem_b[b_ra];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      acc_q         <= '0;
      cur_is_b_q    <= 1'b0;
      grid_rows_q   <= 7'd64;
      grid_cols_q   <= 7'd64;
      coeff_prev_q  <= '0;
      coeff_cur_q   <= '0;
      coeff_nbr_q   <= '0;
      step_period_q <= 16'd1000;
      r_q           <= '0;
      c_q           <= '0;
      k_q           <= '0;
      base_q        <= '0;
      pidx_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GRID_ROWS:   grid_rows_q   <= cfg_data_i[6:0];
          CFG_GRID_COLS:   grid_cols_q   <= cfg_data_i[6:0];
          CFG_COEFF_PREV:  coeff_prev_q  <= $signed(cfg_data_i);
          CFG_COEFF_CUR:   coeff_cur_q   <= $signed(cfg_data_i);
          CFG_COEFF_NBR:   coeff_nbr_q   <= $signed(cfg_data_i);
          CFG_STEP_PERIOD: step_period_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);

      if (in_fire) begin
        pidx_q <= '0;
        r_q    <= '0;
        c_q    <= '0;
        k_q    <= '0;
        base_q <= '0;
        if (opcode_i == OP_TICK) begin
          acc_q <= step_due ? '0 : acc_sat;
          // empty area: the step is only the swap
          if (step_due && no_cells) cur_is_b_q <= !cur_is_b_q;
        end
      end

      if (((state_q == ST_CELL) && is_edge) || (state_q == ST_WB)) begin
        if (last_col) begin
          c_q    <= '0;
          r_q    <= r_q + 7'd1;
          base_q <= base_q + ROW_STRIDE;
          k_q    <= base_q + ROW_STRIDE;
        end else begin
          c_q <= c_q + 7'd1;
          k_q <= k_q + AW'(1);
        end
        if (last_cell) cur_is_b_q <= !cur_is_b_q;
      end

      if (state_q == ST_PWR) pidx_q <= pidx_q + 3'd1;

      if ((state_q == ST_RES) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr_q         <= cell_addr;
      mag_q          <= magnitude_i;
      res_height_q   <= '0;
      res_stepped_q  <= (opcode_i == OP_TICK) && step_due;
      res_rejected_q <= ((opcode_i == OP_PERTURB) && !perturb_ok) ||
                        ((opcode_i == OP_READ) && !read_ok);
    end
    case (state_q)
      ST_DN: begin
        nsum_q    <= 18'(cur_rd_s);
        prv_val_q <= prv_rd_s;
      end
      ST_LF, ST_RT, ST_CT: nsum_q <= nsum_q + 18'(cur_rd_s);
      ST_M1: begin
        ctr_val_q <= cur_rd_s;
        prod_q    <= mul_out;
      end
      ST_M2: begin
        sum_q  <= 36'(prod_q);
        prod_q <= mul_out;
      end
      ST_M3: begin
        sum_q  <= sum_q + 36'(prod_q);
        prod_q <= mul_out;
      end
      ST_M4:  sum_q <= sum_q + 36'(prod_q);
      ST_RDC: res_height_q <= cur_rd_s;
      default: ;
    endcase
    if ((state_q == ST_RES) && out_free) begin
      out_height_q   <= res_height_q;
      out_stepped_q  <= res_stepped_q;
      out_rejected_q <= res_rejected_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign height_o    = out_height_q;
  assign stepped_o   = out_stepped_q;
  assign rejected_o  = out_rejected_q;

`include "wave_grid_stencil_update_unit_assert.svh"

  `WGSU_ASSERT_IMP(a_grid_we_state, a_we || b_we, (state_q == ST_CLEAR) || (state_q == ST_CELL) || (state_q == ST_WB) || (state_q == ST_PWR), "grid written outside a write state")
  `WGSU_ASSERT_IMP(a_flags_excl, out_valid_q, !(out_stepped_q && out_rejected_q), "result both stepped and rejected")
  `WGSU_ASSERT_IMP(a_height_only_read, out_valid_q && (out_stepped_q || out_rejected_q), out_height_q == 16'sd0, "height set on a non-read result")
  `WGSU_ASSERT_NEXT(a_out_from_res, !out_valid_q && (state_q != ST_RES), !out_valid_q, "result beat without a finished item")
  `WGSU_ASSERT_NEXT(a_swap_at_step_end, (state_q == ST_IDLE) && !(in_valid_i && (opcode_i == OP_TICK)), $stable(cur_is_b_q), "grids swapped outside a step")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import wgsu_pkg::*;

  localparam int ROWS_CAP = 64;
  localparam int COLS_CAP = 64;
  localparam int CELLS = ROWS_CAP * COLS_CAP;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 50;
  localparam int CYCLE_LIMIT = 2500000;
  localparam int MAX_REPORTED = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] magnitude;
    logic [15:0]        delta_time;
  } cell_cmd_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic               stepped;
    logic               rejected;
  } cell_report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         opcode_i = OP_TICK;
  logic [5:0]         cell_row_i = '0;
  logic [5:0]         cell_col_i = '0;
  logic signed [15:0] magnitude_i = '0;
  logic [15:0]        delta_time_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] height_o;
  logic               stepped_o;
  logic               rejected_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = CFG_GRID_ROWS;
  logic [15:0]        cfg_data_i = '0;

  // predicted block state: two height planes, one of them current
  logic signed [15:0] plane [0:1][0:CELLS-1];
  logic               cur_sel;
  logic [16:0]        time_acc;
  logic [6:0]         cfg_rows;
  logic [6:0]         cfg_cols;
  logic signed [15:0] k_prev;
  logic signed [15:0] k_cur;
  logic signed [15:0] k_nbr;
  logic [15:0]        step_period;

  cell_report_t predicted_reports[$];
  cell_report_t expected_report;
  cell_report_t got_report;
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_serial = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           cycles_run = 0;

  wave_grid_stencil_update_unit #(
    .MAX_ROWS(ROWS_CAP),
    .MAX_COLS(COLS_CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .magnitude_i (magnitude_i),
    .delta_time_i(delta_time_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .height_o    (height_o),
    .stepped_o   (stepped_o),
    .rejected_o  (rejected_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int active_span(input logic [6:0] n, input int cap);
    return (n > cap) ? cap : int'(n);
  endfunction

  function automatic logic signed [15:0] clamp_q88(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic cell_cmd_t pack_cmd(input logic [1:0] op, input logic [5:0] row,
                                         input logic [5:0] col,
                                         input logic signed [15:0] mag,
                                         input logic [15:0] dt);
    cell_cmd_t cmd;
    cmd.opcode = op;
    cmd.row = row;
    cmd.col = col;
    cmd.magnitude = mag;
    cmd.delta_time = dt;
    return cmd;
  endfunction

  // Applies one accepted command to the predicted state and returns its report.
  function automatic cell_report_t advance_ripple_model(input cell_cmd_t cmd);
    cell_report_t       rep;
    int                 rows;
    int                 cols;
    int                 k;
    logic [17:0]        acc_sum;
    logic signed [63:0] nsum;
    logic signed [63:0] mix;
    logic signed [15:0] half;
    logic               prv_sel;
    rep = '0;
    rows = active_span(cfg_rows, ROWS_CAP);
    cols = active_span(cfg_cols, COLS_CAP);
    prv_sel = ~cur_sel;
    case (cmd.opcode)
      OP_TICK: begin
        acc_sum = time_acc + cmd.delta_time;
        time_acc = (acc_sum > ACC_MAX) ? ACC_MAX : acc_sum[16:0];
        if (time_acc >= step_period) begin
          for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
              k = r * COLS_CAP + c;
              if (r == 0 || c == 0 || r + 1 >= rows || c + 1 >= cols) begin
                plane[prv_sel][k] = '0;
              end else begin
                nsum = 64'(plane[cur_sel][k - COLS_CAP]) + 64'(plane[cur_sel][k + COLS_CAP])
                     + 64'(plane[cur_sel][k - 1]) + 64'(plane[cur_sel][k + 1]);
                mix = 64'(k_prev) * 64'(plane[prv_sel][k])
                    + 64'(k_cur) * 64'(plane[cur_sel][k])
                    + 64'(k_nbr) * nsum;
                // round half up, then floor back to Q8.8
                plane[prv_sel][k] = clamp_q88((mix + 64'sd8192) >>> FRAC_SHIFT);
              end
            end
          end
          cur_sel = prv_sel;
          time_acc = '0;
          rep.stepped = 1'b1;
        end
      end
      OP_PERTURB: begin
        if (cmd.row >= 2 && cmd.row + 2 < rows && cmd.col >= 2 && cmd.col + 2 < cols) begin
          k = cmd.row * COLS_CAP + cmd.col;
          half = cmd.magnitude >>> 1;
          plane[cur_sel][k] = clamp_q88(64'(plane[cur_sel][k]) + 64'(cmd.magnitude));
          plane[cur_sel][k + 1] = clamp_q88(64'(plane[cur_sel][k + 1]) + 64'(half));
          plane[cur_sel][k - 1] = clamp_q88(64'(plane[cur_sel][k - 1]) + 64'(half));
          plane[cur_sel][k + COLS_CAP] =
            clamp_q88(64'(plane[cur_sel][k + COLS_CAP]) + 64'(half));
          plane[cur_sel][k - COLS_CAP] =
            clamp_q88(64'(plane[cur_sel][k - COLS_CAP]) + 64'(half));
        end else begin
          rep.rejected = 1'b1;
        end
      end
      OP_READ: begin
        if (cmd.row < rows && cmd.col < cols) begin
          rep.height = plane[cur_sel][cmd.row * COLS_CAP + cmd.col];
        end else begin
          rep.rejected = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  // Mostly well-formed traffic on the active area, some edge and noise beats.
  function automatic cell_cmd_t random_cmd(input int tick_pct);
    cell_cmd_t cmd;
    int        rows;
    int        cols;
    int        pick;
    rows = active_span(cfg_rows, ROWS_CAP);
    cols = active_span(cfg_cols, COLS_CAP);
    cmd.opcode = OP_UNUSED;
    cmd.row = $urandom_range(0, 63);
    cmd.col = $urandom_range(0, 63);
    cmd.magnitude = $urandom;
    cmd.delta_time = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < tick_pct) begin
      cmd.opcode = OP_TICK;
      if ($urandom_range(0, 3) != 0) cmd.delta_time = $urandom_range(0, step_period / 2);
    end else if (pick < tick_pct + 45) begin
      cmd.opcode = OP_PERTURB;
      if ($urandom_range(0, 99) < 85 && rows >= 5 && cols >= 5) begin
        cmd.row = $urandom_range(2, rows - 3);
        cmd.col = $urandom_range(2, cols - 3);
      end
      if ($urandom_range(0, 3) != 0) cmd.magnitude = 16'($urandom_range(0, 4095) - 2048);
    end else if (pick < 95) begin
      cmd.opcode = OP_READ;
      if ($urandom_range(0, 99) < 85) begin
        cmd.row = $urandom_range(0, rows - 1);
        cmd.col = $urandom_range(0, cols - 1);
      end
    end
    return cmd;
  endfunction

  task automatic offer_cmd(input cell_cmd_t cmd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= cmd.opcode;
    cell_row_i   <= cmd.row;
    cell_col_i   <= cmd.col;
    magnitude_i  <= cmd.magnitude;
    delta_time_i <= cmd.delta_time;
    do @(posedge clk_i); while (in_stall_o);
    predicted_reports.push_back(advance_ripple_model(cmd));
  endtask

  task automatic wait_for_reports();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_reports.size() != 0);
  endtask

  task automatic put_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_GRID_ROWS:   cfg_rows = data[6:0];
      CFG_GRID_COLS:   cfg_cols = data[6:0];
      CFG_COEFF_PREV:  k_prev = data;
      CFG_COEFF_CUR:   k_cur = data;
      CFG_COEFF_NBR:   k_nbr = data;
      CFG_STEP_PERIOD: step_period = data;
      default: begin
      end
    endcase
  endtask

  // only called once the block has returned every pending report
  task automatic write_config(input logic [6:0] rows, input logic [6:0] cols,
                              input logic signed [15:0] kp, input logic signed [15:0] kc,
                              input logic signed [15:0] kn, input logic [15:0] period);
    put_reg(CFG_GRID_ROWS, {9'd0, rows});
    put_reg(CFG_GRID_COLS, {9'd0, cols});
    put_reg(CFG_COEFF_PREV, kp);
    put_reg(CFG_COEFF_CUR, kc);
    put_reg(CFG_COEFF_NBR, kn);
    put_reg(CFG_STEP_PERIOD, period);
    cfg_valid_i <= 1'b0;
  endtask

  // register values straight out of reset: full grid, zero weights
  task automatic test_reset_state();
    offer_cmd(pack_cmd(OP_READ, 6'd0, 6'd0, 16'sd0, 16'd0));
    offer_cmd(pack_cmd(OP_PERTURB, 6'd2, 6'd2, 16'sh7FFF, 16'd0));
    offer_cmd(pack_cmd(OP_PERTURB, 6'd61, 6'd61, 16'sh8000, 16'd0));
    offer_cmd(pack_cmd(OP_PERTURB, 6'd62, 6'd10, 16'sd100, 16'd0));
    offer_cmd(pack_cmd(OP_READ, 6'd2, 6'd3, 16'sd0, 16'd0));
    offer_cmd(pack_cmd(OP_TICK, 6'd0, 6'd0, 16'sd0, 16'd999));
    offer_cmd(pack_cmd(OP_TICK, 6'd0, 6'd0, 16'sd0, 16'd1));
    offer_cmd(pack_cmd(OP_READ, 6'd2, 6'd2, 16'sd0, 16'd0));
  endtask

  // extreme weights and heights on a tiny grid, saturating both ways
  task automatic test_saturation_extremes();
    wait_for_reports();
    write_config(7'd5, 7'd6, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'd1);
    offer_cmd(pack_cmd(OP_PERTURB, 6'd2, 6'd2, 16'sh7FFF, 16'd0));
    offer_cmd(pack_cmd(OP_PERTURB, 6'd2, 6'd3, 16'sh8000, 16'd0));
    offer_cmd(pack_cmd(OP_READ, 6'd2, 6'd3, 16'sd0, 16'd0));
    offer_cmd(pack_cmd(OP_TICK, 6'd0, 6'd0, 16'sd0, 16'd0));
    offer_cmd(pack_cmd(OP_TICK, 6'd0, 6'd0, 16'sd0, 16'hFFFF));
    offer_cmd(pack_cmd(OP_READ, 6'd2, 6'd2, 16'sd0, 16'd0));
    offer_cmd(pack_cmd(OP_READ, 6'd4, 6'd5, 16'sd0, 16'd0));
    offer_cmd(pack_cmd(OP_READ, 6'd5, 6'd0, 16'sd0, 16'd0));
    offer_cmd(pack_cmd(OP_READ, 6'd0, 6'd6, 16'sd0, 16'd0));
    offer_cmd(pack_cmd(OP_UNUSED, 6'd63, 6'd63, 16'shFFFF, 16'hFFFF));
  endtask

  // oversized and undersized grids, zero and full-scale step period
  task automatic test_dimension_limits();
    wait_for_reports();
    write_config(7'd100, 7'd3, 16'sd0, 16'sd16384, 16'sd4096, 16'd0);
    offer_cmd(pack_cmd(OP_PERTURB, 6'd30, 6'd1, 16'sd500, 16'd0));
    offer_cmd(pack_cmd(OP_TICK, 6'd0, 6'd0, 16'sd0, 16'd0));
    offer_cmd(pack_cmd(OP_READ, 6'd63, 6'd2, 16'sd0, 16'd0));
    offer_cmd(pack_cmd(OP_READ, 6'd63, 6'd3, 16'sd0, 16'd0));
    wait_for_reports();
    write_config(7'd2, 7'd64, 16'sd16384, 16'sd0, 16'sd0, 16'hFFFF);
    offer_cmd(pack_cmd(OP_PERTURB, 6'd0, 6'd10, 16'sd700, 16'd0));
    offer_cmd(pack_cmd(OP_TICK, 6'd0, 6'd0, 16'sd0, 16'hFFFE));
    offer_cmd(pack_cmd(OP_TICK, 6'd0, 6'd0, 16'sd0, 16'hFFFF));
    offer_cmd(pack_cmd(OP_READ, 6'd1, 6'd63, 16'sd0, 16'd0));
  endtask

  // receiver blocks for a long stretch while beats keep coming
  task automatic test_backpressure();
    wait_for_reports();
    write_config(7'd10, 7'd10, -16'sd16200, 16'sd28000, 16'sd1100, 16'd500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_serial <= hold_serial + 1;
    repeat (14) offer_cmd(random_cmd(10));
    wait_for_reports();
  endtask

  task automatic test_random_mix(input int sender_pct, input int receiver_pct,
                                 input bit wild_weights);
    logic [6:0]         rows;
    logic [6:0]         cols;
    logic signed [15:0] kp;
    logic signed [15:0] kc;
    logic signed [15:0] kn;
    logic [15:0]        period;
    int                 wave;
    for (int part = 0; part < 2; part++) begin
      wait_for_reports();
      rows = $urandom_range(5, 12);
      cols = $urandom_range(5, 12);
      case ($urandom_range(0, 3))
        0: rows = $urandom_range(65, 127);
        1: cols = 7'd64;
        default: begin
        end
      endcase
      if (wild_weights && part == 1) begin
        kp = $urandom;
        kc = $urandom;
        kn = $urandom;
      end else begin
        wave = $urandom_range(300, 4000);
        kn = 16'(wave);
        kc = 16'(32767 - 4 * wave);
        kp = 16'(-16384 + int'($urandom_range(0, 400)));
      end
      case ($urandom_range(0, 2))
        0: period = $urandom_range(1, 8);
        1: period = $urandom_range(9, 2000);
        default: period = $urandom_range(30000, 65535);
      endcase
      write_config(rows, cols, kp, kc, kn, period);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      repeat (21) offer_cmd(random_cmd(20));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_report = {height_o, stepped_o, rejected_o};
      if (predicted_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTED)
          $display("unexpected beat: height %0d stepped %0b rejected %0b",
                   got_report.height, got_report.stepped, got_report.rejected);
      end else begin
        expected_report = predicted_reports.pop_front();
        if (got_report !== expected_report) begin
          fail_count++;
          if (fail_count <= MAX_REPORTED)
            $display("mismatch: expected height %0d stepped %0b rejected %0b, got %0d %0b %0b",
                     expected_report.height, expected_report.stepped,
                     expected_report.rejected, got_report.height, got_report.stepped,
                     got_report.rejected);
        end
      end
    end
    if (hold_serial != hold_seen) begin
      hold_seen   <= hold_serial;
      hold_left   <= HOLD_OFF_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < CELLS; k++) plane[s][k] = '0;
    end
    cur_sel = 1'b0;
    time_acc = '0;
    cfg_rows = 7'd64;
    cfg_cols = 7'd64;
    k_prev = '0;
    k_cur = '0;
    k_nbr = '0;
    step_period = 16'd1000;
    send_idle_pct = 20;
    recv_idle_pct = 30;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_saturation_extremes();
    test_dimension_limits();
    test_backpressure();
    test_random_mix(9, 81, 1'b0);
    test_random_mix(81, 9, 1'b1);
    test_random_mix(0, 0, 1'b1);
    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && predicted_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
